### design/preemptive_priority_scheduler_unit_defines.svh
// Assertion macros for the preemptive priority scheduler checker.
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_UNIT_DEFINES_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_UNIT_DEFINES_SVH

// clocked on clk, off while rst_n is low
`define PPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked on clk, checked during reset too
`define PPS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/pps_pkg.sv
// Types and constants shared by the preemptive priority scheduler files.
`default_nettype none
package pps_pkg;

  localparam int MAX_TASKS_DEF = 16;
  localparam int IDX_W  = 4;
  localparam int TIME_W = 16;
  localparam int PRIO_W = 8;
  localparam int CNT_W  = 5;
  localparam int CLK_W  = 32;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic [IDX_W-1:0]  task_index;
    logic [TIME_W-1:0] arrival;
    logic [TIME_W-1:0] burst;
    logic [PRIO_W-1:0] prio;
  } in_t;

  typedef struct packed {
    logic             idle;
    logic [IDX_W-1:0] task_id;
    logic [CLK_W-1:0] slot_start;
    logic             finished;
    logic [CLK_W-1:0] turnaround;
    logic [CLK_W-1:0] waiting;
    logic             all_done;
  } out_t;

  typedef struct packed {
    logic [TIME_W-1:0] arrive;
    logic [TIME_W-1:0] remaining;
    logic [TIME_W-1:0] orig_burst;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  typedef struct packed {
    logic clr;
    logic eval;
  } scan_ctl_t;

endpackage
`default_nettype wire

### design/pps_mem.sv
// Task table: one write port, one read port, registered read data.
`default_nettype none
module pps_mem #(
  parameter int DEPTH = pps_pkg::MAX_TASKS_DEF,
  parameter int AW    = 4
) (
  input  wire logic            clk,
  input  wire logic            wr_en,
  input  wire logic [AW-1:0]   wr_addr,
  input  wire pps_pkg::entry_t wr_data,
  input  wire logic            rd_en,
  input  wire logic [AW-1:0]   rd_addr,
  output pps_pkg::entry_t      rd_data
);
  import pps_pkg::*;

  entry_t mem_r [DEPTH];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

### design/pps_scan.sv
// Running minimum-priority search over the task entries, one entry a cycle.
`default_nettype none
module pps_scan #(
  parameter int AW = 4
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire pps_pkg::scan_ctl_t       ctl,
  input  wire logic [AW-1:0]            idx,
  input  wire logic                     vld,
  input  wire pps_pkg::entry_t          ent,
  input  wire logic [pps_pkg::CLK_W-1:0] now,
  output logic                          found,
  output logic [AW-1:0]                 best_idx,
  output pps_pkg::entry_t               best_ent
);
  import pps_pkg::*;

  logic          found_r, found_nxt;
  logic [AW-1:0] best_idx_r;
  entry_t        best_ent_r;
  logic          ready;
  logic          take;

  assign ready = vld && (ent.remaining != '0) && (CLK_W'(ent.arrive) <= now);
  assign take  = ctl.eval && ready && (!found_r || (ent.prio < best_ent_r.prio));

  always_comb begin
    found_nxt = found_r;
    if (ctl.clr) begin
      found_nxt = 1'b0;
    end else if (take) begin
      found_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else begin
      found_r <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_idx_r <= idx;
      best_ent_r <= ent;
    end
  end

  assign found    = found_r;
  assign best_idx = best_idx_r;
  assign best_ent = best_ent_r;

endmodule
`default_nettype wire

### design/preemptive_priority_scheduler_unit.sv
// Top level of the tick-driven preemptive priority scheduler.
//
// Requests enter on in_data when start is high and busy is low. A load
// request writes one task entry and clears the time counter and the
// completion count; a tick request runs the ready task with the lowest
// priority number (lowest index on ties) for one time unit.
// Every request gives one result on out_data, marked by out_valid for one
// cycle; the receiver cannot stall it.
// A load keeps busy low, and its result shows in the next cycle. A tick
// once every task is done is handled the same way.
// Any other tick keeps busy high until its result: the table is read one
// entry a cycle for the search over the tasks in use, then the entry is
// written back if a task was found, the turnaround is worked out, and the
// waiting time is worked out as the result register is loaded; out_valid
// rises as busy falls. task_count is to be written by the user on cfg_we
// only while no request is in flight; the block does not enforce this.
// Reset (rst_n low, synchronous) clears the per-entry valid bits, the time,
// the completion count, and sets task_count to one; no clearing pass.
`default_nettype none
module preemptive_priority_scheduler_unit #(
  parameter int MAX_TASKS = pps_pkg::MAX_TASKS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  output logic                          busy,
  input  wire pps_pkg::in_t             in_data,
  output logic                          out_valid,
  output pps_pkg::out_t                 out_data,
  input  wire logic                     cfg_we,
  input  wire logic [pps_pkg::CNT_W-1:0] cfg_wdata
);
  import pps_pkg::*;

  localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_COMMIT = 3'd2;
  localparam logic [2:0] ST_TURN   = 3'd3;
  localparam logic [2:0] ST_REPORT = 3'd4;

  logic [2:0]           state_r, state_nxt;
  logic [CNT_W-1:0]     task_count_r, task_count_nxt;
  logic [CLK_W-1:0]     now_r, now_nxt;
  logic [CNT_W-1:0]     done_r, done_nxt;
  logic [MAX_TASKS-1:0] valid_r, valid_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 pend_r, pend_nxt;
  logic                 out_valid_r, out_valid_nxt;

  logic [AW-1:0]        rd_idx_r, rd_idx_nxt;
  logic [CLK_W-1:0]     start_time_r, start_time_nxt;
  logic                 fin_r, fin_nxt;
  logic [CLK_W-1:0]     turn_r, turn_nxt;
  out_t                 out_r, out_nxt;

  logic [CNT_W-1:0]     n_use;
  logic                 accept;
  logic                 load_ok;
  logic                 rd_en;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  entry_t               wr_data;
  entry_t               rd_data;
  scan_ctl_t            scan_ctl;
  logic                 found;
  logic [AW-1:0]        best_idx;
  entry_t               best_ent;
  logic [TIME_W-1:0]    rem_dec;
  logic [CLK_W-1:0]     orig_ext;

  assign n_use   = (32'(task_count_r) > MAX_TASKS) ? CNT_W'(MAX_TASKS) : task_count_r;
  assign busy    = (state_r != ST_IDLE);
  assign accept  = start && !busy;
  assign load_ok = (32'(in_data.task_index) < MAX_TASKS);
  assign rd_en   = (state_r == ST_SCAN) && (cnt_r < n_use);
  assign rem_dec = best_ent.remaining - 1'b1;
  assign orig_ext = CLK_W'(best_ent.orig_burst);

  assign scan_ctl.clr  = accept;
  assign scan_ctl.eval = (state_r == ST_SCAN) && pend_r;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = best_idx;
    wr_data = best_ent;
    wr_data.remaining = rem_dec;
    if (accept && (in_data.req_type == REQ_LOAD)) begin
      wr_en   = load_ok;
      wr_addr = AW'(in_data.task_index);
      wr_data.arrive     = in_data.arrival;
      wr_data.remaining  = in_data.burst;
      wr_data.orig_burst = in_data.burst;
      wr_data.prio       = in_data.prio;
    end else if ((state_r == ST_COMMIT) && found) begin
      wr_en = 1'b1;
    end
  end

  pps_mem #(
    .DEPTH (MAX_TASKS),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (AW'(cnt_r)),
    .rd_data (rd_data)
  );

  pps_scan #(
    .AW (AW)
  ) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (scan_ctl),
    .idx      (rd_idx_r),
    .vld      (valid_r[rd_idx_r]),
    .ent      (rd_data),
    .now      (now_r),
    .found    (found),
    .best_idx (best_idx),
    .best_ent (best_ent)
  );

  always_comb begin
    state_nxt      = state_r;
    task_count_nxt = task_count_r;
    now_nxt        = now_r;
    done_nxt       = done_r;
    valid_nxt      = valid_r;
    cnt_nxt        = cnt_r;
    pend_nxt       = pend_r;
    out_valid_nxt  = 1'b0;
    rd_idx_nxt     = rd_idx_r;
    start_time_nxt = start_time_r;
    fin_nxt        = fin_r;
    turn_nxt       = turn_r;
    out_nxt        = out_r;

    if (cfg_we) begin
      task_count_nxt = cfg_wdata;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          out_nxt = '0;
          out_nxt.idle = 1'b1;
          if (in_data.req_type == REQ_LOAD) begin
            if (load_ok) begin
              valid_nxt[AW'(in_data.task_index)] = 1'b1;
            end
            now_nxt          = '0;
            done_nxt         = '0;
            out_nxt.all_done = (n_use == '0);
            out_valid_nxt    = 1'b1;
          end else if (done_r >= n_use) begin
            out_nxt.slot_start = now_r;
            out_nxt.all_done   = 1'b1;
            out_valid_nxt      = 1'b1;
          end else begin
            start_time_nxt = now_r;
            cnt_nxt        = '0;
            pend_nxt       = 1'b0;
            state_nxt      = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        pend_nxt = rd_en;
        if (rd_en) begin
          cnt_nxt    = cnt_r + 1'b1;
          rd_idx_nxt = AW'(cnt_r);
        end else if (pend_r) begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        now_nxt = (now_r == '1) ? now_r : now_r + 1'b1;
        fin_nxt = found && (rem_dec == '0);
        if (found && (rem_dec == '0) && (done_r != '1)) begin
          done_nxt = done_r + 1'b1;
        end
        state_nxt = ST_TURN;
      end
      ST_TURN: begin
        turn_nxt  = now_r - CLK_W'(best_ent.arrive);
        state_nxt = ST_REPORT;
      end
      ST_REPORT: begin
        out_nxt            = '0;
        out_nxt.idle       = !found;
        out_nxt.task_id    = found ? IDX_W'(best_idx) : '0;
        out_nxt.slot_start = start_time_r;
        out_nxt.finished   = fin_r;
        if (fin_r) begin
          out_nxt.turnaround = turn_r;
          out_nxt.waiting    = (turn_r >= orig_ext) ? turn_r - orig_ext : '0;
        end
        out_nxt.all_done = (done_r >= n_use);
        out_valid_nxt    = 1'b1;
        state_nxt        = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      task_count_r <= CNT_W'(1);
      now_r        <= '0;
      done_r       <= '0;
      valid_r      <= '0;
      cnt_r        <= '0;
      pend_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      task_count_r <= task_count_nxt;
      now_r        <= now_nxt;
      done_r       <= done_nxt;
      valid_r      <= valid_nxt;
      cnt_r        <= cnt_nxt;
      pend_r       <= pend_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r     <= rd_idx_nxt;
    start_time_r <= start_time_nxt;
    fin_r        <= fin_nxt;
    turn_r       <= turn_nxt;
    out_r        <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

### design/pps_checker.sv
// Port-level checks for the preemptive priority scheduler, bound to the top level.
`default_nettype none
`include "preemptive_priority_scheduler_unit_defines.svh"
module pps_checker (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          start,
  input wire logic          busy,
  input wire pps_pkg::in_t  in_data,
  input wire logic          out_valid,
  input wire pps_pkg::out_t out_data
);
  import pps_pkg::*;

  `PPS_ASSERT(a_load_result, start && !busy && (in_data.req_type == REQ_LOAD) |=> out_valid && out_data.idle && (out_data.slot_start == '0), "load request gave no idle result at time zero")
  `PPS_ASSERT(a_report_on_release, $fell(busy) && $past(rst_n) |-> out_valid, "tick finished without a result")
  `PPS_ASSERT(a_no_result_while_busy, out_valid |-> !busy, "result shown while a tick is in flight")
  `PPS_ASSERT_ALWAYS(a_finish_sane, !rst_n || !out_valid || !out_data.finished || (!out_data.idle && (out_data.waiting <= out_data.turnaround)), "finished result is idle or waits beyond its turnaround")

endmodule

bind preemptive_priority_scheduler_unit pps_checker u_pps_checker (.*);
`default_nettype wire
